// ===== hw/rtl/srcache_pkg.sv =====
// ----------------------------------------------------------------------------
// srcache_pkg
// shared constants, codes and types of the scored replacement cache
// ----------------------------------------------------------------------------
package srcache_pkg;

	// fixed field widths
	localparam int AGE_BITS       = 32;
	localparam int HITS_BITS      = 32;
	localparam int WEIGHT_BITS    = 8;
	localparam int LIMIT_BITS     = 4;
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 8;

	// register reset values
	localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = 4'd5;
	localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 8'd2;

	// command code carried on the input tuser
	localparam logic CMD_CLEAR = 1'b1;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_ENTRIES = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HIT_WEIGHT  = 1'b1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} state_t;

endpackage

// ===== hw/rtl/srcache_mem.sv =====
// ----------------------------------------------------------------------------
// srcache_mem
// entry memory: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module srcache_mem #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rdata_q;

endmodule

// ===== hw/rtl/scored_replacement_cache.sv =====
// ----------------------------------------------------------------------------
// scored_replacement_cache
// fully associative tag cache with age plus weighted hit count replacement
// ----------------------------------------------------------------------------
// usage
//   s_axis: one request beat, tuser = command (1 clears the whole cache),
//   tdata = key, fill_valid, fill_data. m_axis: one result beat per request,
//   tuser = hit, tdata = data, inserted, evicted, evicted_key.
//   cfg: register writes (0 max_entries_used, 1 hit_weight), always ready;
//   write only while no request is in flight.
// sequence
//   a lookup reads every entry, one entry a cycle through the single read
//   port; a drain step waits until the read data and score stages are empty,
//   then the decide step decides and writes back once the output register is
//   free. a clear skips the scan and drain and goes straight to the decide step.
//   one request is in flight at a time; the next can be taken once the result
//   is in the output register.
// reset
//   all entries invalid, age zero, registers at 5 and 2. entry memory is not
//   cleared; only entries marked valid are ever used.
// stall
//   a result waits in the output register; a further result waits in the
//   decide step until the output register is free.
// ----------------------------------------------------------------------------
module scored_replacement_cache #(
	parameter int ENTRIES   = 8,
	parameter int KEY_BITS  = 32,
	parameter int DATA_BITS = 32,
	localparam int IN_BITS  = ((KEY_BITS + 1 + DATA_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = ((DATA_BITS + 2 + KEY_BITS + 7) / 8) * 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	// key, fill_valid, fill_data
	input  logic [IN_BITS-1:0]                      s_axis_tdata,
	// command
	input  logic                                    s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	// data, inserted, evicted, evicted_key
	output logic [OUT_BITS-1:0]                     m_axis_tdata,
	// hit
	output logic                                    m_axis_tuser,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [srcache_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [srcache_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	import srcache_pkg::*;

	localparam int IW         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW         = $clog2(ENTRIES + 1);
	localparam int WORD_BITS  = KEY_BITS + DATA_BITS + AGE_BITS + HITS_BITS;
	localparam int PROD_BITS  = WEIGHT_BITS + HITS_BITS;
	localparam int SCORE_BITS = PROD_BITS + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	// control state
	state_t                 state_q, state_d;
	logic                   cmd_q;
	logic [LIMIT_BITS-1:0]  max_q;
	logic [WEIGHT_BITS-1:0] weight_q;
	logic [AGE_BITS-1:0]    age_q;
	logic [ENTRIES-1:0]     valid_q, valid_d;
	logic [ENTRIES-1:0]     stale_q, stale_d;
	logic [IW-1:0]          iss_idx_q;

	// request payload
	logic [KEY_BITS-1:0]    key_q;
	logic                   fill_v_q;
	logic [DATA_BITS-1:0]   fill_q;

	// scan pipeline
	logic                   rd_v_s1;
	logic [IW-1:0]          idx_s1;
	logic                   v_s2;
	logic                   live_s2;
	logic [KEY_BITS-1:0]    key_s2;
	logic [AGE_BITS-1:0]    birth_s2;
	logic [PROD_BITS-1:0]   prod_s2;
	logic [IW-1:0]          idx_s2;

	// scan results
	logic                   hit_q;
	logic [IW-1:0]          hit_idx_q;
	logic [DATA_BITS-1:0]   hit_pay_q;
	logic [AGE_BITS-1:0]    hit_birth_q;
	logic [HITS_BITS-1:0]   hit_hits_q;
	logic                   free_found_q;
	logic [IW-1:0]          free_idx_q;
	logic [CW-1:0]          cnt_q;
	logic                   vic_found_q;
	logic [IW-1:0]          vic_idx_q;
	logic [KEY_BITS-1:0]    vic_key_q;
	logic [SCORE_BITS-1:0]  best_q;

	// output register
	logic                   out_v_q;
	logic                   out_hit_q;
	logic [DATA_BITS-1:0]   out_data_q;
	logic                   out_ins_q;
	logic                   out_ev_q;
	logic [KEY_BITS-1:0]    out_evk_q;

	// sequencer strobes
	logic rd_en, start, fire;

	// memory ports
	logic [WORD_BITS-1:0]  rdata;
	logic                  mem_we;
	logic [IW-1:0]         mem_waddr;
	logic [WORD_BITS-1:0]  mem_wdata;

	// read word fields
	logic [KEY_BITS-1:0]   r_key;
	logic [DATA_BITS-1:0]  r_pay;
	logic [AGE_BITS-1:0]   r_birth;
	logic [HITS_BITS-1:0]  r_hits;
	logic                  r_live;
	logic                  r_match;

	// decide logic
	logic [AGE_BITS-1:0]   age_inc;
	logic                  advance;
	logic [7:0]            lim8;
	logic                  need_evict;
	logic [IW-1:0]         slot;
	logic                  slot_ok;
	logic                  do_fill;
	logic [HITS_BITS-1:0]  hits_sat;
	logic [SCORE_BITS-1:0] score_s2;
	logic                  better_s2;

	srcache_mem #(
		.DEPTH (ENTRIES),
		.WIDTH (WORD_BITS)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (iss_idx_q),
		.rd_data (rdata),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		start   = 1'b0;
		fire    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					start   = 1'b1;
					state_d = (s_axis_tuser == CMD_CLEAR) ? ST_DECIDE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (iss_idx_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_v_s1 && !v_s2) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!out_v_q || m_axis_tready) begin
					fire    = 1'b1;
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;

	// split the word read back from memory
	assign r_key   = rdata[WORD_BITS-1 -: KEY_BITS];
	assign r_pay   = rdata[AGE_BITS + HITS_BITS +: DATA_BITS];
	assign r_birth = rdata[HITS_BITS +: AGE_BITS];
	assign r_hits  = rdata[HITS_BITS-1:0];
	assign r_live  = valid_q[idx_s1];
	assign r_match = r_live && (r_key == key_q);

	// score of the entry in the second stage
	assign score_s2  = SCORE_BITS'(birth_s2) + SCORE_BITS'(prod_s2);
	assign better_s2 = !vic_found_q || (score_s2 < best_q) ||
		((score_s2 == best_q) && (key_s2 < vic_key_q));

	// decide: limit, victim, free slot, write-back word
	always_comb begin
		age_inc = age_q + AGE_BITS'(1);
		lim8    = (max_q == '0) ? 8'd1 : 8'(max_q);
		if (lim8 > 8'(ENTRIES)) begin
			lim8 = 8'(ENTRIES);
		end
		do_fill    = !cmd_q && !hit_q && fill_v_q;
		need_evict = vic_found_q && (8'(cnt_q) >= lim8);
		if (need_evict) begin
			slot    = (free_found_q && (free_idx_q < vic_idx_q)) ? free_idx_q : vic_idx_q;
			slot_ok = 1'b1;
		end else begin
			slot    = free_idx_q;
			slot_ok = free_found_q;
		end
		advance  = !cmd_q && (hit_q || do_fill);
		hits_sat = (hit_hits_q == '1) ? hit_hits_q : hit_hits_q + HITS_BITS'(1);

		mem_we    = fire && !cmd_q && (hit_q || (do_fill && slot_ok));
		mem_waddr = hit_q ? hit_idx_q : slot;
		mem_wdata = hit_q ? {key_q, hit_pay_q, hit_birth_q, hits_sat}
		                  : {key_q, fill_q, age_inc, HITS_BITS'(0)};

		valid_d = valid_q;
		stale_d = stale_q;
		if (cmd_q) begin
			valid_d = '0;
		end else begin
			if (advance && (age_inc == '0)) begin
				stale_d = '1;
			end
			if (do_fill && need_evict) begin
				valid_d[vic_idx_q] = 1'b0;
			end
			if (do_fill && slot_ok) begin
				valid_d[slot] = 1'b1;
				stale_d[slot] = 1'b0;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cmd_q        <= 1'b0;
			max_q        <= LIMIT_RESET;
			weight_q     <= WEIGHT_RESET;
			age_q        <= '0;
			valid_q      <= '0;
			stale_q      <= '0;
			iss_idx_q    <= '0;
			rd_v_s1      <= 1'b0;
			v_s2         <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			vic_found_q  <= 1'b0;
			cnt_q        <= '0;
			out_v_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= rd_en;
			v_s2    <= rd_v_s1;

			// configuration beat
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MAX_ENTRIES: max_q    <= cfg_data[LIMIT_BITS-1:0];
					REG_HIT_WEIGHT:  weight_q <= cfg_data[WEIGHT_BITS-1:0];
				endcase
			end

			// new request clears the scan trackers
			if (start) begin
				cmd_q        <= (s_axis_tuser == CMD_CLEAR);
				iss_idx_q    <= '0;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
				vic_found_q  <= 1'b0;
				cnt_q        <= '0;
			end

			// read address walks the entries
			if (rd_en && (iss_idx_q != LAST_IDX)) begin
				iss_idx_q <= iss_idx_q + IW'(1);
			end

			// first stage trackers
			if (rd_v_s1) begin
				if (r_match) begin
					hit_q <= 1'b1;
				end
				if (!r_live && !free_found_q) begin
					free_found_q <= 1'b1;
				end
				if (r_live) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end

			// second stage victim tracker
			if (v_s2 && live_s2 && better_s2) begin
				vic_found_q <= 1'b1;
			end

			// decide
			if (fire) begin
				valid_q <= valid_d;
				stale_q <= stale_d;
				if (advance) begin
					age_q <= age_inc;
				end
			end

			// output beat handshake
			if (fire) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (start) begin
			key_q    <= s_axis_tdata[KEY_BITS-1:0];
			fill_v_q <= s_axis_tdata[KEY_BITS];
			fill_q   <= s_axis_tdata[KEY_BITS + 1 +: DATA_BITS];
		end

		if (rd_en) begin
			idx_s1 <= iss_idx_q;
		end

		// first stage: match capture, product of weight and hits
		// births count as zero when stale or when this fill wraps the age
		if (rd_v_s1) begin
			if (r_match) begin
				hit_idx_q   <= idx_s1;
				hit_pay_q   <= r_pay;
				hit_birth_q <= r_birth;
				hit_hits_q  <= r_hits;
			end
			if (!r_live && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
			live_s2  <= r_live;
			key_s2   <= r_key;
			birth_s2 <= (stale_q[idx_s1] || (age_inc == '0)) ? AGE_BITS'(0) : r_birth;
			prod_s2  <= PROD_BITS'(weight_q) * PROD_BITS'(r_hits);
			idx_s2   <= idx_s1;
		end

		// second stage: keep the lowest score, ties to the smaller key
		if (v_s2 && live_s2 && better_s2) begin
			best_q    <= score_s2;
			vic_idx_q <= idx_s2;
			vic_key_q <= key_s2;
		end

		// result beat
		if (fire) begin
			out_hit_q  <= hit_q;
			out_data_q <= cmd_q ? DATA_BITS'(0) :
			              hit_q ? hit_pay_q :
			              do_fill ? fill_q : DATA_BITS'(0);
			out_ins_q  <= do_fill && slot_ok;
			out_ev_q   <= do_fill && need_evict;
			out_evk_q  <= (do_fill && need_evict) ? vic_key_q : KEY_BITS'(0);
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = out_hit_q;
	assign m_axis_tdata  = OUT_BITS'({out_evk_q, out_ev_q, out_ins_q, out_data_q});

	// checks
	a_mem_write_in_decide: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_DECIDE))
		else $error("entry memory written outside the decide step");

	a_result_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_DECIDE))
		else $error("result beat raised without a decide step");

	a_hit_no_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_hit_q) |-> (!out_ins_q && !out_ev_q))
		else $error("hit result also reports a fill or eviction");

	a_evict_implies_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_ev_q) |-> out_ins_q)
		else $error("eviction without insertion");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cmd_q) |=> (valid_q == '0))
		else $error("clear left valid entries");

endmodule

// ===== sim/srcache_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// srcache_checker
// watches the request, result and register channels of the scored
// replacement cache, keeps a cycle-free model of the cache contents, and
// compares every result beat field by field with the oldest prediction
// ----------------------------------------------------------------------------
module srcache_checker #(
	parameter int ENTRIES   = 8,
	parameter int KEY_BITS  = 32,
	parameter int DATA_BITS = 32,
	parameter int IN_BITS   = 72,
	parameter int OUT_BITS  = 72
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	input  logic                                   s_axis_tready,
	// key, fill_valid, fill_data
	input  logic [IN_BITS-1:0]                     s_axis_tdata,
	// command
	input  logic                                   s_axis_tuser,
	input  logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// data, inserted, evicted, evicted_key
	input  logic [OUT_BITS-1:0]                    m_axis_tdata,
	// hit
	input  logic                                   m_axis_tuser,
	input  logic                                   cfg_valid,
	input  logic                                   cfg_ready,
	input  logic [srcache_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [srcache_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output int                                     outstanding,
	output int                                     errors
);

	import srcache_pkg::*;

	typedef struct packed {
		logic                 hit;
		logic [DATA_BITS-1:0] data;
		logic                 inserted;
		logic                 evicted;
		logic [KEY_BITS-1:0]  evicted_key;
	} cache_result_t;

	// shadow copy of the cache
	logic                   line_valid   [ENTRIES];
	logic [KEY_BITS-1:0]    line_key     [ENTRIES];
	logic [DATA_BITS-1:0]   line_payload [ENTRIES];
	logic [AGE_BITS-1:0]    line_birth   [ENTRIES];
	logic [HITS_BITS-1:0]   line_hits    [ENTRIES];
	logic [AGE_BITS-1:0]    age_now;
	logic [LIMIT_BITS-1:0]  limit_reg;
	logic [WEIGHT_BITS-1:0] weight_reg;

	cache_result_t expected_results [$];
	cache_result_t want;
	cache_result_t got;

	task automatic report_mismatch(input string what, input logic [63:0] seen,
			input logic [63:0] wanted);
		errors++;
		if (errors <= 40)
			$display("%0t ns mismatch on %s: got %0h, expected %0h", $realtime, what,
				seen, wanted);
	endtask

	// a hit or an accepted fill moves the age; a wrap clears all births
	function automatic void tick_age();
		age_now = age_now + AGE_BITS'(1);
		if (age_now == '0)
			for (int i = 0; i < ENTRIES; i++)
				line_birth[i] = '0;
	endfunction

	// predicts one result and updates the shadow cache
	function automatic cache_result_t cache_access(input logic cmd,
			input logic [KEY_BITS-1:0] tag, input logic fill_ok,
			input logic [DATA_BITS-1:0] fill);
		cache_result_t r;
		int unsigned   eff_limit;
		int unsigned   occupied;
		int            victim;
		int            slot;
		longint unsigned score;
		longint unsigned best;
		r = '0;
		if (cmd == CMD_CLEAR) begin
			for (int i = 0; i < ENTRIES; i++)
				line_valid[i] = 1'b0;
			return r;
		end
		// tag search
		for (int i = 0; i < ENTRIES; i++) begin
			if (line_valid[i] && line_key[i] == tag) begin
				tick_age();
				if (line_hits[i] != '1)
					line_hits[i] = line_hits[i] + HITS_BITS'(1);
				r.hit  = 1'b1;
				r.data = line_payload[i];
				return r;
			end
		end
		if (!fill_ok)
			return r;
		tick_age();
		// out of range limits clamp to 1 .. ENTRIES
		eff_limit = (limit_reg == 0) ? 1 : limit_reg;
		if (eff_limit > ENTRIES)
			eff_limit = ENTRIES;
		occupied = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (line_valid[i])
				occupied++;
		// lowest score goes, ties to the smaller tag
		if (occupied >= eff_limit) begin
			victim = -1;
			best   = 0;
			for (int i = 0; i < ENTRIES; i++) begin
				if (!line_valid[i])
					continue;
				score = longint'(line_birth[i]) + longint'(weight_reg) * longint'(line_hits[i]);
				if (victim < 0 || score < best ||
						(score == best && line_key[i] < line_key[victim])) begin
					best   = score;
					victim = i;
				end
			end
			if (victim >= 0) begin
				line_valid[victim] = 1'b0;
				r.evicted          = 1'b1;
				r.evicted_key      = line_key[victim];
			end
		end
		// first free slot takes the fill
		slot = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!line_valid[i]) begin
				slot = i;
				break;
			end
		end
		if (slot >= 0) begin
			line_valid[slot]   = 1'b1;
			line_key[slot]     = tag;
			line_payload[slot] = fill;
			line_birth[slot]   = age_now;
			line_hits[slot]    = '0;
			r.inserted         = 1'b1;
		end
		r.data = fill;
		return r;
	endfunction

	// channel monitor: results first, then registers, then new requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				line_valid[i] = 1'b0;
			age_now    = '0;
			limit_reg  = LIMIT_RESET;
			weight_reg = WEIGHT_RESET;
			expected_results.delete();
			outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result beat with nothing pending",
						m_axis_tdata[63:0], '0);
				end else begin
					want            = expected_results.pop_front();
					got.hit         = m_axis_tuser;
					got.data        = m_axis_tdata[DATA_BITS-1:0];
					got.inserted    = m_axis_tdata[DATA_BITS];
					got.evicted     = m_axis_tdata[DATA_BITS+1];
					got.evicted_key = m_axis_tdata[DATA_BITS+2 +: KEY_BITS];
					if (got.hit !== want.hit)
						report_mismatch("hit", 64'(got.hit), 64'(want.hit));
					if (got.data !== want.data)
						report_mismatch("data", 64'(got.data), 64'(want.data));
					if (got.inserted !== want.inserted)
						report_mismatch("inserted", 64'(got.inserted),
							64'(want.inserted));
					if (got.evicted !== want.evicted)
						report_mismatch("evicted", 64'(got.evicted), 64'(want.evicted));
					if (got.evicted_key !== want.evicted_key)
						report_mismatch("evicted_key", 64'(got.evicted_key),
							64'(want.evicted_key));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_ENTRIES: limit_reg = cfg_data[LIMIT_BITS-1:0];
					REG_HIT_WEIGHT:  weight_reg = cfg_data[WEIGHT_BITS-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(cache_access(s_axis_tuser,
					s_axis_tdata[KEY_BITS-1:0], s_axis_tdata[KEY_BITS],
					s_axis_tdata[KEY_BITS+1 +: DATA_BITS]));
			outstanding <= outstanding + ((s_axis_tvalid && s_axis_tready) ? 1 : 0)
				- ((m_axis_tvalid && m_axis_tready) ? 1 : 0);
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the scored replacement cache
// ----------------------------------------------------------------------------
// a directed opening walks hits, misses with and without fill, eviction,
// clear, score ties and a lowered limit; then random phases under
// different register settings, clamped limits among them, mix a small
// tag pool with random tags. the sender runs in bursts, the receiver
// stalls on its own pattern and once holds off long enough to back the
// cache up. srcache_checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
	import srcache_pkg::*;

	localparam int ENTRIES     = 8;
	localparam int KEY_BITS    = 32;
	localparam int DATA_BITS   = 32;
	localparam int IN_BITS     = ((KEY_BITS + 1 + DATA_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = ((DATA_BITS + 2 + KEY_BITS + 7) / 8) * 8;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 57;
	localparam int HOLD_AT     = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 2 * (ENTRIES + 5);
	localparam int CYCLE_LIMIT = 200000;

	localparam logic CMD_LOOKUP = ~CMD_CLEAR;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [IN_BITS-1:0]        s_axis_tdata = '0;
	logic                      s_axis_tuser = 1'b0;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [OUT_BITS-1:0]       m_axis_tdata;
	logic                      m_axis_tuser;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	int outstanding;
	int check_errors;
	int cycle_count = 0;
	int result_beats = 0;
	int burst_left = 0;
	logic [KEY_BITS-1:0] tag_pool [16];

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	scored_replacement_cache #(
		.ENTRIES   (ENTRIES),
		.KEY_BITS  (KEY_BITS),
		.DATA_BITS (DATA_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	srcache_checker #(
		.ENTRIES   (ENTRIES),
		.KEY_BITS  (KEY_BITS),
		.DATA_BITS (DATA_BITS),
		.IN_BITS   (IN_BITS),
		.OUT_BITS  (OUT_BITS)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.outstanding   (outstanding),
		.errors        (check_errors)
	);

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result beats seen, for the long hold-off
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			result_beats <= result_beats + 1;
	end

	// receiver: random stall modes, one long hold-off
	initial begin
		int  run_len;
		int  mode;
		bit  held;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && result_beats >= HOLD_AT) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
			end else begin
				mode    = $urandom_range(2);
				run_len = $urandom_range(60, 10);
				repeat (run_len) begin
					case (mode)
						0: m_axis_tready <= 1'b1;
						1: m_axis_tready <= 1'($urandom_range(1));
						default: m_axis_tready <= ($urandom_range(3) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// one request beat, sent inside a burst; gaps fall between bursts
	task automatic send_beat(input logic cmd, input logic [KEY_BITS-1:0] tag,
			input logic fill_ok, input logic [DATA_BITS-1:0] fill);
		logic [IN_BITS-1:0] beat_bits;
		int                 gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(6);
			burst_left = ($urandom_range(9) == 0) ? 50 : $urandom_range(12, 1);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		beat_bits                           = '0;
		beat_bits[KEY_BITS-1:0]             = tag;
		beat_bits[KEY_BITS]                 = fill_ok;
		beat_bits[KEY_BITS+1 +: DATA_BITS]  = fill;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= beat_bits;
		s_axis_tuser  <= cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
	endtask

	// stop sending and let every pending result drain
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// both registers, back to back; upper bits of the limit beat are don't-care
	task automatic write_regs(input logic [LIMIT_BITS-1:0] limit,
			input logic [WEIGHT_BITS-1:0] weight);
		cfg_valid <= 1'b1;
		cfg_index <= REG_MAX_ENTRIES;
		cfg_data  <= {4'($urandom_range(15)), limit};
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= REG_HIT_WEIGHT;
		cfg_data  <= weight;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stimulus
	initial begin
		logic [LIMIT_BITS-1:0]  phase_limit  [PHASES];
		logic [WEIGHT_BITS-1:0] phase_weight [PHASES];
		logic                   cmd;
		logic [KEY_BITS-1:0]    tag;
		logic                   fill_ok;
		phase_limit  = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd4, 4'd3, 4'd0};
		phase_weight = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd1, 8'd0, 8'd0};
		phase_limit[PHASES-1]  = LIMIT_BITS'($urandom_range(15));
		phase_weight[PHASES-2] = WEIGHT_BITS'($urandom_range(255));
		phase_weight[PHASES-1] = WEIGHT_BITS'($urandom_range(255));
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int i = 2; i < 16; i++)
			tag_pool[i] = $urandom;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: miss without fill, fills, hits, eviction, clear
		send_beat(CMD_LOOKUP, '0, 1'b0, $urandom);
		send_beat(CMD_LOOKUP, '0, 1'b1, '1);
		send_beat(CMD_LOOKUP, '0, 1'b0, '0);
		send_beat(CMD_LOOKUP, '1, 1'b1, '0);
		send_beat(CMD_LOOKUP, '1, 1'b1, $urandom);
		for (int i = 2; i < 6; i++)
			send_beat(CMD_LOOKUP, tag_pool[i], 1'b1, $urandom);
		send_beat(CMD_CLEAR, $urandom, 1'b1, $urandom);
		send_beat(CMD_LOOKUP, '0, 1'b0, $urandom);

		// equal scores: the smaller tag goes
		wait_idle();
		write_regs(4'd2, 8'd1);
		send_beat(CMD_LOOKUP, '1, 1'b1, $urandom);
		send_beat(CMD_LOOKUP, KEY_BITS'(1), 1'b1, $urandom);
		send_beat(CMD_LOOKUP, '1, 1'b0, $urandom);
		send_beat(CMD_LOOKUP, KEY_BITS'(32'h8000_0000), 1'b1, $urandom);

		// fill to eight, then lower the limit under the occupancy
		wait_idle();
		write_regs(4'd8, 8'd3);
		for (int i = 2; i < 8; i++)
			send_beat(CMD_LOOKUP, tag_pool[i], 1'b1, $urandom);
		wait_idle();
		write_regs(4'd3, 8'd3);
		send_beat(CMD_LOOKUP, tag_pool[8], 1'b1, $urandom);
		send_beat(CMD_LOOKUP, tag_pool[9], 1'b1, $urandom);

		// random phases, one register setting each
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			write_regs(phase_limit[p], phase_weight[p]);
			repeat (PHASE_ITEMS) begin
				cmd     = ($urandom_range(99) < 3) ? CMD_CLEAR : CMD_LOOKUP;
				tag     = ($urandom_range(99) < 85) ? tag_pool[4'($urandom_range(15))]
				                                    : $urandom;
				fill_ok = ($urandom_range(99) < 75);
				send_beat(cmd, tag, fill_ok, $urandom);
			end
		end

		wait_idle();
		if (check_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
